FILE: design/prwd_pkg.sv
// Shared constants and types of the pixel readout word decoder.
package prwd_pkg;

	// Matrix size in pixels.
	localparam int unsigned NUM_COLS = 400;
	localparam int unsigned NUM_ROWS = 192;

	// Tag of a synthesized header, and reset value of the held ids.
	localparam logic [9:0]  SYNTH_TAG    = 10'd666;
	localparam logic [9:0]  TRIG_ID_RST  = 10'd666;
	localparam logic [14:0] BUNCH_ID_RST = 15'd666;

	// Filler words carry all ones in their upper half.
	localparam logic [15:0] FILLER_MARK = 16'hFFFF;

	// Charge code of an empty pixel.
	localparam logic [3:0] CHARGE_NONE = 4'hF;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_HIT     = 2'd1,
		KIND_INVALID = 2'd2
	} kind_t;

endpackage

FILE: design/prwd_if.sv
// Handshake channels of the decoder: readout words in, decoded results out.
interface prwd_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic        fragment_start;

	modport source (output valid, output word, output fragment_start, input ready);
	modport sink   (input valid, input word, input fragment_start, output ready);
endinterface

interface prwd_result_if;
	logic            valid;
	logic            ready;
	prwd_pkg::kind_t kind;
	logic [9:0]      event_tag;
	logic [9:0]      trigger_id;
	logic [14:0]     bunch_id;
	logic [7:0]      pixel_row;
	logic [8:0]      pixel_col;
	logic [3:0]      charge;
	logic            last;

	modport source (output valid, output kind, output event_tag, output trigger_id,
		output bunch_id, output pixel_row, output pixel_col, output charge,
		output last, input ready);
	modport sink (input valid, input kind, input event_tag, input trigger_id,
		input bunch_id, input pixel_row, input pixel_col, input charge,
		input last, output ready);
endinterface

FILE: design/pixel_readout_word_decoder.sv
// Pixel readout word decoder: top level with decode, result expansion and output register.
// Results pass from the expansion stage through the output register. Throughput: one result
// per cycle while results.ready is not held low; a word is accepted every cycle as long as the
// previous word has at most one result left and the output register moves, so the results of
// one word go out one at a time through the single result register. Fillers and words with no
// result leave the expansion stage empty, so they never stall the words that follow them.
// Reset (arst_n low) clears all valid flags, closes the event and sets both held ids to 666.
module pixel_readout_word_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	prwd_word_if.sink             words,
	prwd_result_if.source         results
);

	// Held event state. It is updated when a word is accepted, so each word is decoded
	// against the state left by all words before it, even while older results still wait.
	logic [9:0]  trig_id_q;
	logic [14:0] bunch_id_q;
	logic        event_open_q;

	// Expansion stage: one decoded word waiting to be sent out as up to five results.
	// Slot 0 is a header or invalid-address result, slots 1 to 4 are the four pixels.
	logic [4:0]            slots_s1;
	prwd_pkg::kind_t       kind0_s1;
	logic [9:0]            tag0_s1;
	logic [9:0]            trig_id_s1;
	logic [14:0]           bunch_id_s1;
	logic [7:0]            row_s1;
	logic [8:0]            col_s1;
	logic [15:0]           charges_s1;

	// Output register.
	logic                  out_valid_q;
	prwd_pkg::kind_t       out_kind_q;
	logic [9:0]            out_tag_q;
	logic [9:0]            out_trig_id_q;
	logic [14:0]           out_bunch_id_q;
	logic [7:0]            out_row_q;
	logic [8:0]            out_col_q;
	logic [3:0]            out_charge_q;
	logic                  out_last_q;

	// Decode of the incoming word.
	logic        in_accept;
	logic        is_filler;
	logic        is_header;
	logic        open_eff;
	logic [8:0]  col_base;
	logic [8:0]  row_base;
	logic        in_range;
	logic [3:0]  pix_mask;
	logic [4:0]  slots_new;
	logic [9:0]  next_trig_id;
	logic [14:0] next_bunch_id;
	logic        next_open;

	// Expansion control.
	logic        advance;
	logic [4:0]  pick;
	logic [4:0]  slots_rest;
	logic [3:0]  pick_charge;
	logic [8:0]  pick_col;

	always_comb begin
		is_filler = (words.word[31:16] == prwd_pkg::FILLER_MARK);
		is_header = words.word[25];
		// A fragment start closes the open event before the word itself is looked at.
		open_eff  = event_open_q & ~words.fragment_start;
		// Core column times eight plus four for an odd region; core row times eight plus
		// the upper region bits. Both are plain bit concatenations.
		col_base  = {words.word[31:26], words.word[16], 2'b00};
		row_base  = {words.word[25:20], words.word[19:17]};
		in_range  = ({1'b0, col_base} < 10'(prwd_pkg::NUM_COLS)) &&
			({1'b0, row_base} < 10'(prwd_pkg::NUM_ROWS));
		for (int i = 0; i < 4; i++) begin
			pix_mask[i] = (words.word[4*i +: 4] != prwd_pkg::CHARGE_NONE);
		end

		next_trig_id  = trig_id_q;
		next_bunch_id = bunch_id_q;
		next_open     = open_eff;
		slots_new     = '0;
		if (is_header) begin
			next_trig_id  = {5'd0, words.word[24:20]};
			next_bunch_id = words.word[14:0];
			next_open     = 1'b1;
			slots_new     = 5'b00001;
		end else if (in_range) begin
			// A hit outside an open event first gets a synthesized header.
			next_open     = 1'b1;
			slots_new     = {pix_mask, ~open_eff};
		end else begin
			slots_new     = 5'b00001;
		end
		if (is_filler) begin
			next_trig_id  = trig_id_q;
			next_bunch_id = bunch_id_q;
			next_open     = open_eff;
			slots_new     = '0;
		end
	end

	// Lowest pending slot goes out next.
	always_comb begin
		pick = slots_s1 & (~slots_s1 + 5'd1);
		slots_rest = slots_s1 & ~pick;
		pick_charge = '0;
		pick_col = col_s1;
		priority if (pick[1]) begin
			pick_charge = charges_s1[3:0] + 4'd1;
		end else if (pick[2]) begin
			pick_charge = charges_s1[7:4] + 4'd1;
			pick_col = col_s1 + 9'd1;
		end else if (pick[3]) begin
			pick_charge = charges_s1[11:8] + 4'd1;
			pick_col = col_s1 + 9'd2;
		end else if (pick[4]) begin
			pick_charge = charges_s1[15:12] + 4'd1;
			pick_col = col_s1 + 9'd3;
		end else begin
			pick_charge = '0;
		end
	end

	// The output register takes a new result when it is empty or being read.
	assign advance     = ~out_valid_q | results.ready;
	// A new word may enter when the expansion stage is empty or sends its final result now.
	assign words.ready = (slots_s1 == '0) || (advance && (slots_rest == '0));
	assign in_accept   = words.valid & words.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_id_q    <= prwd_pkg::TRIG_ID_RST;
			bunch_id_q   <= prwd_pkg::BUNCH_ID_RST;
			event_open_q <= 1'b0;
			slots_s1     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_accept) begin
				trig_id_q    <= next_trig_id;
				bunch_id_q   <= next_bunch_id;
				event_open_q <= next_open;
			end

			if (slots_s1 != '0 && advance) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_accept) begin
				slots_s1 <= slots_new;
			end else if (advance) begin
				slots_s1 <= slots_rest;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_accept && slots_new != '0) begin
			if (is_header || in_range) begin
				kind0_s1 <= prwd_pkg::KIND_HEADER;
			end else begin
				kind0_s1 <= prwd_pkg::KIND_INVALID;
			end
			tag0_s1     <= is_header ? {5'd0, words.word[19:15]}
				: (in_range ? prwd_pkg::SYNTH_TAG : 10'd0);
			trig_id_s1  <= next_trig_id;
			bunch_id_s1 <= next_bunch_id;
			row_s1      <= 8'(row_base + 9'd1);
			col_s1      <= col_base + 9'd1;
			charges_s1  <= words.word[15:0];
		end

		if (slots_s1 != '0 && advance) begin
			out_trig_id_q  <= trig_id_s1;
			out_bunch_id_q <= bunch_id_s1;
			out_last_q     <= (slots_rest == '0);
			if (pick[0]) begin
				out_kind_q   <= kind0_s1;
				out_tag_q    <= tag0_s1;
				out_row_q    <= '0;
				out_col_q    <= '0;
				out_charge_q <= '0;
			end else begin
				out_kind_q   <= prwd_pkg::KIND_HIT;
				out_tag_q    <= '0;
				out_row_q    <= row_s1;
				out_col_q    <= pick_col;
				out_charge_q <= pick_charge;
			end
		end
	end

	assign results.valid       = out_valid_q;
	assign results.kind        = out_kind_q;
	assign results.event_tag   = out_tag_q;
	assign results.trigger_id  = out_trig_id_q;
	assign results.bunch_id    = out_bunch_id_q;
	assign results.pixel_row   = out_row_q;
	assign results.pixel_col   = out_col_q;
	assign results.charge      = out_charge_q;
	assign results.last        = out_last_q;

endmodule
